### rtl/nps_pkg.sv
`default_nettype none

package nps_pkg;

    localparam int MAX_HOPS   = 16;
    localparam int IDX_W      = $clog2(MAX_HOPS);
    localparam int CNT_W      = $clog2(MAX_HOPS + 1);
    localparam int NUM_TAGS   = 4;
    localparam int ID_W       = 16;
    localparam int PRIO_W     = 16;
    localparam int RULE_W     = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int NARROW_STEPS = 7;
    localparam int STEP_W     = $clog2(NARROW_STEPS);
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 16;

    // tag positions, also the register index of each tag rule
    localparam int TAG_WIRED    = 0;
    localparam int TAG_WIFI     = 1;
    localparam int TAG_CELLULAR = 2;
    localparam int TAG_TRUSTED  = 3;

    typedef logic [RULE_W-1:0] rule_t;
    typedef rule_t [NUM_TAGS-1:0] rules_t;

    localparam rule_t RULE_NEUTRAL  = 3'd0;
    localparam rule_t RULE_REQUIRE  = 3'd1;
    localparam rule_t RULE_PREFER   = 3'd2;
    localparam rule_t RULE_AVOID    = 3'd3;
    localparam rule_t RULE_PROHIBIT = 3'd4;

    localparam logic MODE_FORWARD   = 1'b0;
    localparam logic MODE_ADVERTISE = 1'b1;

    // one classified candidate as it travels from front to back
    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [NUM_TAGS-1:0] tags;
        logic [PRIO_W-1:0]   prio;
        logic                local_win;
        logic                eligible;
        logic                last;
    } hop_rec_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PICK,
        ST_NARROW,
        ST_SCAN,
        ST_FILTER,
        ST_EMIT
    } back_state_t;

endpackage

`default_nettype wire

### rtl/nexthop_policy_select.sv
// Policy-driven next hop selection.
// Candidate hops arrive on the s_ stream, one beat per hop; s_tlast marks the
// final candidate of a set, whose mode and ingress come from its first beat.
// Tag rules are written on the cfg_ channel (index 0 wired, 1 wifi,
// 2 cellular, 3 trusted); the user must write them only while the block
// is idle, as the block itself does not enforce it.
// The selected hop ids leave on the m_ stream in load order, m_tuser high,
// m_tlast on the final one; a set with nothing selected gives one beat with
// m_tuser low and m_tlast high.
// Candidates enter the four-entry queue one per cycle while it has room and
// are stored one per cycle while the back end loads; after the last is
// stored the single back-end sequencer goes straight to emit when local hops
// win or nothing is eligible, else through narrowing steps, a priority scan
// and a filter, and results leave one per cycle while m_tready is high. Up
// to four candidates of the next set queue up meanwhile before s_tready drops.
// A stalled m_tready holds the output beat and the emit state; the queue
// keeps accepting until full. Reset clears the rules, the queue, the store
// count and the output valid.
`default_nettype none

module nexthop_policy_select (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // ingress_id, hop_id, hop_present, hop_up, hop_local, tag_wired, tag_wifi,
    // tag_cellular, tag_trusted, hop_priority, zero pad
    input  wire logic [nps_pkg::S_DATA_W-1:0]    s_tdata,
    // mode
    input  wire logic                            s_tuser,
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // sel_id
    output logic [nps_pkg::M_DATA_W-1:0]         m_tdata,
    // sel_valid
    output logic                                 m_tuser,
    output logic                                 m_tlast,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [nps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [nps_pkg::RULE_W-1:0]      cfg_data
);
    import nps_pkg::*;

    rules_t   rules_reg, rules_next;
    hop_rec_t q_din, q_dout;
    logic     q_push, q_full, q_pop, q_empty;

    assign cfg_ready = 1'b1;

    always_comb begin
        rules_next = rules_reg;
        if (cfg_valid && cfg_ready && cfg_index < CFG_IDX_W'(NUM_TAGS)) begin
            rules_next[cfg_index[1:0]] = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rules_reg <= {NUM_TAGS{RULE_NEUTRAL}};
        end else begin
            rules_reg <= rules_next;
        end
    end

    nps_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rules    (rules_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_push   (q_push),
        .q_din    (q_din),
        .q_full   (q_full)
    );

    nps_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .empty   (q_empty)
    );

    nps_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rules    (rules_reg),
        .q_dout   (q_dout),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

### rtl/nps_fifo.sv
`default_nettype none

module nps_fifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire nps_pkg::hop_rec_t din,
    output logic                   full,
    input  wire logic              pop,
    output nps_pkg::hop_rec_t      dout,
    output logic                   empty
);
    import nps_pkg::*;

    hop_rec_t            mem_reg [FIFO_DEPTH];
    logic [FPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full    = (cnt_reg == FCNT_W'(FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

### rtl/nps_front.sv
`default_nettype none

module nps_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire nps_pkg::rules_t                rules,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // ingress_id, hop_id, hop_present, hop_up, hop_local, tag_wired, tag_wifi,
    // tag_cellular, tag_trusted, hop_priority, zero pad
    input  wire logic [nps_pkg::S_DATA_W-1:0]   s_tdata,
    // mode
    input  wire logic                           s_tuser,
    input  wire logic                           s_tlast,
    output logic                                q_push,
    output nps_pkg::hop_rec_t                   q_din,
    input  wire logic                           q_full
);
    import nps_pkg::*;

    logic              open_reg, open_next;
    logic              mode_reg, mode_next;
    logic [ID_W-1:0]   ingress_reg, ingress_next;

    logic              beat;
    logic              mode_eff, fwd, not_ingress, present, up, is_local, tag_ok;
    logic [ID_W-1:0]   ingress_eff, hop_id;
    logic [NUM_TAGS-1:0] tags;

    assign s_tready = !q_full;
    assign beat     = s_tvalid && s_tready;

    assign hop_id   = s_tdata[31:16];
    assign present  = s_tdata[32];
    assign up       = s_tdata[33];
    assign is_local = s_tdata[34];
    assign tags     = s_tdata[38:35];

    // mode and ingress come from the first beat of a set
    assign mode_eff    = open_reg ? mode_reg : s_tuser;
    assign ingress_eff = open_reg ? ingress_reg : s_tdata[15:0];
    assign fwd         = (mode_eff == MODE_FORWARD);
    assign not_ingress = (hop_id != ingress_eff);

    always_comb begin
        tag_ok = 1'b1;
        for (int t = 0; t < NUM_TAGS; t++) begin
            if (rules[t] == RULE_REQUIRE && !tags[t]) tag_ok = 1'b0;
            if (rules[t] == RULE_PROHIBIT && tags[t]) tag_ok = 1'b0;
        end
    end

    always_comb begin
        q_din.id        = hop_id;
        q_din.tags      = tags;
        q_din.prio      = s_tdata[54:39];
        q_din.local_win = fwd && is_local && present && up && not_ingress;
        q_din.eligible  = present && up && (fwd ? not_ingress : !is_local) && tag_ok;
        q_din.last      = s_tlast;
    end

    assign q_push = beat;

    always_comb begin
        open_next    = open_reg;
        mode_next    = mode_reg;
        ingress_next = ingress_reg;
        if (beat) begin
            open_next    = !s_tlast;
            mode_next    = mode_eff;
            ingress_next = ingress_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg    <= 1'b0;
            mode_reg    <= 1'b0;
            ingress_reg <= '0;
        end else begin
            open_reg    <= open_next;
            mode_reg    <= mode_next;
            ingress_reg <= ingress_next;
        end
    end

endmodule

`default_nettype wire

### rtl/nps_back.sv
`default_nettype none

module nps_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire nps_pkg::rules_t                rules,
    input  wire nps_pkg::hop_rec_t              q_dout,
    input  wire logic                           q_empty,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // sel_id
    output logic [nps_pkg::M_DATA_W-1:0]        m_tdata,
    // sel_valid
    output logic                                m_tuser,
    output logic                                m_tlast
);
    import nps_pkg::*;

    back_state_t         state_reg, state_next;

    logic [ID_W-1:0]     id_reg   [MAX_HOPS];
    logic [NUM_TAGS-1:0] tag_reg  [MAX_HOPS];
    logic [PRIO_W-1:0]   prio_reg [MAX_HOPS];
    logic [MAX_HOPS-1:0] lw_reg;
    logic [MAX_HOPS-1:0] ok_reg;
    logic [MAX_HOPS-1:0] vld_reg, vld_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [MAX_HOPS-1:0] sel_reg, sel_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [PRIO_W-1:0]   maxp_reg, maxp_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [ID_W-1:0]     m_id_reg, m_id_next;
    logic                m_sv_reg, m_sv_next;
    logic                m_last_reg, m_last_next;

    logic                dup, store_en, out_ld, emit_fire, emit_done;
    logic [MAX_HOPS-1:0] tagm [NUM_TAGS];
    logic [MAX_HOPS-1:0] keep, narrowed, lw_mask, ok_mask, first_oh, prio_hit;
    logic [IDX_W-1:0]    first_idx;
    logic [1:0]          tsel;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_id_reg;
    assign m_tuser  = m_sv_reg;
    assign m_tlast  = m_last_reg;

    assign out_ld    = !m_tvalid_reg || m_tready;
    assign q_pop     = (state_reg == ST_LOAD) && !q_empty;
    assign emit_fire = (state_reg == ST_EMIT) && out_ld;

    always_comb begin
        dup = 1'b0;
        for (int i = 0; i < MAX_HOPS; i++) begin
            if (vld_reg[i] && id_reg[i] == q_dout.id) dup = 1'b1;
        end
    end

    assign store_en = q_pop && !dup && (cnt_reg < CNT_W'(MAX_HOPS));

    always_comb begin
        for (int t = 0; t < NUM_TAGS; t++) begin
            for (int i = 0; i < MAX_HOPS; i++) begin
                tagm[t][i] = tag_reg[i][t];
            end
        end
        for (int i = 0; i < MAX_HOPS; i++) begin
            prio_hit[i] = (prio_reg[i] == maxp_reg);
        end
    end

    assign lw_mask = lw_reg & vld_reg;
    assign ok_mask = ok_reg & vld_reg;

    // narrowing sequence: trusted, avoid per tag, prefer per tag, the last two for wired, wifi and cellular only
    always_comb begin
        keep = '1;
        tsel = 2'(TAG_WIRED);
        if (step_reg == '0) begin
            if (rules[TAG_TRUSTED] == RULE_REQUIRE || rules[TAG_TRUSTED] == RULE_PREFER) begin
                keep = tagm[TAG_TRUSTED];
            end else begin
                keep = ~tagm[TAG_TRUSTED];
            end
        end else if (step_reg < STEP_W'(4)) begin
            tsel = 2'(step_reg - STEP_W'(1));
            if (rules[tsel] == RULE_AVOID) keep = ~tagm[tsel];
        end else begin
            tsel = 2'(step_reg - STEP_W'(4));
            if (rules[tsel] == RULE_PREFER) keep = tagm[tsel];
        end
        narrowed = ((sel_reg & keep) != '0) ? (sel_reg & keep) : sel_reg;
    end

    always_comb begin
        first_idx = '0;
        for (int i = MAX_HOPS - 1; i >= 0; i--) begin
            if (sel_reg[i]) first_idx = IDX_W'(i);
        end
        first_oh = '0;
        first_oh[first_idx] = sel_reg[first_idx];
    end

    assign emit_done = ((sel_reg & ~first_oh) == '0);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (q_pop && q_dout.last) state_next = ST_PICK;
            end
            ST_PICK: begin
                if (lw_mask != '0 || ok_mask == '0) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_NARROW;
                end
            end
            ST_NARROW: begin
                if (step_reg == STEP_W'(NARROW_STEPS - 1)) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (idx_reg == IDX_W'(MAX_HOPS - 1)) state_next = ST_FILTER;
            end
            ST_FILTER: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_ld && emit_done) state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        sel_next  = sel_reg;
        step_next = step_reg;
        idx_next  = idx_reg;
        maxp_next = maxp_reg;
        vld_next  = vld_reg;
        cnt_next  = cnt_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (store_en) begin
                    vld_next[cnt_reg[IDX_W-1:0]] = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_PICK: begin
                sel_next  = (lw_mask != '0) ? lw_mask : ok_mask;
                step_next = '0;
            end
            ST_NARROW: begin
                sel_next  = narrowed;
                step_next = step_reg + 1'b1;
                idx_next  = '0;
                maxp_next = '0;
            end
            ST_SCAN: begin
                if (sel_reg[idx_reg] && prio_reg[idx_reg] > maxp_reg) begin
                    maxp_next = prio_reg[idx_reg];
                end
                idx_next = idx_reg + 1'b1;
            end
            ST_FILTER: begin
                sel_next = sel_reg & prio_hit;
            end
            ST_EMIT: begin
                if (out_ld) begin
                    sel_next = sel_reg & ~first_oh;
                    if (emit_done) begin
                        vld_next = '0;
                        cnt_next = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_id_next     = m_id_reg;
        m_sv_next     = m_sv_reg;
        m_last_next   = m_last_reg;
        if (out_ld) begin
            m_tvalid_next = emit_fire;
        end
        if (emit_fire) begin
            if (sel_reg == '0) begin
                m_id_next = '0;
                m_sv_next = 1'b0;
            end else begin
                m_id_next = id_reg[first_idx];
                m_sv_next = 1'b1;
            end
            m_last_next = emit_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            vld_reg      <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            vld_reg      <= vld_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sel_reg    <= sel_next;
        step_reg   <= step_next;
        idx_reg    <= idx_next;
        maxp_reg   <= maxp_next;
        m_id_reg   <= m_id_next;
        m_sv_reg   <= m_sv_next;
        m_last_reg <= m_last_next;
        if (store_en) begin
            id_reg[cnt_reg[IDX_W-1:0]]   <= q_dout.id;
            tag_reg[cnt_reg[IDX_W-1:0]]  <= q_dout.tags;
            prio_reg[cnt_reg[IDX_W-1:0]] <= q_dout.prio;
            lw_reg[cnt_reg[IDX_W-1:0]]   <= q_dout.local_win;
            ok_reg[cnt_reg[IDX_W-1:0]]   <= q_dout.eligible;
        end
    end

endmodule

`default_nettype wire
